/* rtl/core/lttc_pkg.sv */
package lttc_pkg;

  localparam int ENTRIES       = 16;
  localparam int PENDING_SLOTS = 8;
  localparam int KEY_BITS      = 32;
  localparam int VALUE_BITS    = 64;
  localparam int TIME_BITS     = 32;
  localparam int TTL_BITS      = 24;
  localparam int STAT_BITS     = 32;
  localparam int LIMIT_BITS    = 5;

  localparam int EW = $clog2(ENTRIES);
  localparam int PW = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;

  localparam logic [1:0] ACT_LOOKUP = 2'd0;
  localparam logic [1:0] ACT_FILL   = 2'd1;
  localparam logic [1:0] ACT_INVAL  = 2'd2;
  localparam logic [1:0] ACT_CLEAR  = 2'd3;

  localparam logic [3:0] ST_HIT     = 4'd0;
  localparam logic [3:0] ST_MISS    = 4'd1;
  localparam logic [3:0] ST_MERGED  = 4'd2;
  localparam logic [3:0] ST_FULL    = 4'd3;
  localparam logic [3:0] ST_STORED  = 4'd4;
  localparam logic [3:0] ST_FAILED  = 4'd5;
  localparam logic [3:0] ST_INVAL   = 4'd6;
  localparam logic [3:0] ST_ABSENT  = 4'd7;
  localparam logic [3:0] ST_CLEARED = 4'd8;

  typedef struct packed {
    logic [1:0]            action;
    logic [KEY_BITS-1:0]   key;
    logic [TIME_BITS-1:0]  now_ms;
    logic [TTL_BITS-1:0]   ttl_ms;
    logic [VALUE_BITS-1:0] fill_value;
    logic                  fill_ok;
  } in_t;

  typedef struct packed {
    logic [3:0]            status;
    logic [KEY_BITS-1:0]   key_echo;
    logic [VALUE_BITS-1:0] read_value;
    logic [EW:0]           entry_count;
    logic [STAT_BITS-1:0]  hit_count;
    logic [STAT_BITS-1:0]  miss_count;
    logic [STAT_BITS-1:0]  eviction_count;
    logic [STAT_BITS-1:0]  merged_count;
  } out_t;

  typedef struct packed {
    logic hit;
    logic miss;
    logic evict;
    logic merged;
  } bump_t;

  typedef struct packed {
    logic [STAT_BITS-1:0] hit;
    logic [STAT_BITS-1:0] miss;
    logic [STAT_BITS-1:0] evict;
    logic [STAT_BITS-1:0] merged;
  } stats_t;

endpackage

/* rtl/core/lttc_ram.sv */
module lttc_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(D)-1:0]         waddr,
  input  logic [W-1:0]                 wdata,
  input  logic [$clog2(D)-1:0]         raddr,
  output logic [W-1:0]                 rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/core/lttc_stats.sv */
module lttc_stats (
  input  logic           clk,
  input  logic           rst_n,
  input  lttc_pkg::bump_t bump,
  output lttc_pkg::stats_t stats
);
  import lttc_pkg::*;

  stats_t cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (bump.hit && cnt_r.hit != '1) cnt_nxt.hit = cnt_r.hit + 1'b1;
    if (bump.miss && cnt_r.miss != '1) cnt_nxt.miss = cnt_r.miss + 1'b1;
    if (bump.evict && cnt_r.evict != '1) cnt_nxt.evict = cnt_r.evict + 1'b1;
    if (bump.merged && cnt_r.merged != '1) cnt_nxt.merged = cnt_r.merged + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign stats = cnt_r;
endmodule

/* rtl/core/lru_ttl_cache_with_miss_merge_unit.sv */
// Sequence: every item scans all entries, then a lookup hit, a removal or a fill runs a rank pass;
// a fill then writes its entry, and each eviction over the entry limit adds another rank pass.
// Throughput: one transaction at a time; the rank memory port is visited once per entry per pass.
// Reset: synchronous active low; entry and pending valid bits, counters and control clear,
// entry_limit returns to 16. Memory contents need no clearing.
module lru_ttl_cache_with_miss_merge_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lttc_pkg::in_t     in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output lttc_pkg::out_t    out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [lttc_pkg::LIMIT_BITS-1:0] cfg_data
);
  import lttc_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_PASS   = 3'd3;
  localparam logic [2:0] S_WRITE  = 3'd4;
  localparam logic [2:0] S_LIMIT  = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  localparam logic [1:0] M_HIT    = 2'd0;
  localparam logic [1:0] M_REMOVE = 2'd1;
  localparam logic [1:0] M_FILL   = 2'd2;
  localparam logic [1:0] M_EVICT  = 2'd3;

  localparam int EDW = KEY_BITS + VALUE_BITS + TIME_BITS;

  logic [2:0]             state_r, state_nxt;
  logic [1:0]             mode_r, mode_nxt;
  logic [EW:0]            cnt_r, cnt_nxt;
  in_t                    item_r, item_nxt;
  logic [ENTRIES-1:0]     valid_r, valid_nxt;
  logic [PENDING_SLOTS-1:0] pvalid_r, pvalid_nxt;
  logic [LIMIT_BITS-1:0]  lim_r, lim_nxt;
  logic                   found_r, found_nxt;
  logic [EW-1:0]          s_r, s_nxt;
  logic [EW-1:0]          rank_r, rank_nxt;
  logic [VALUE_BITS-1:0]  val_r, val_nxt;
  logic [TIME_BITS-1:0]   exp_r, exp_nxt;
  logic                   pm_r, pm_nxt;
  logic                   pf_r, pf_nxt;
  logic [PW-1:0]          pfree_r, pfree_nxt;
  logic                   evf_r, evf_nxt;
  logic [EW:0]            tgt_r, tgt_nxt;
  logic [3:0]             status_r, status_nxt;
  logic [VALUE_BITS-1:0]  rval_r, rval_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_t                   out_r, out_nxt;

  bump_t                  bump;
  stats_t                 stats;

  logic                   e_we;
  logic [EW-1:0]          e_waddr, e_raddr;
  logic [EDW-1:0]         e_wdata, e_rdata;
  logic                   r_we;
  logic [EW-1:0]          r_waddr, r_raddr;
  logic [EW-1:0]          r_wdata, r_rdata;
  logic                   p_we;
  logic [PW-1:0]          p_waddr, p_raddr;
  logic [KEY_BITS-1:0]    p_rdata;

  logic [EW:0]            jx;
  logic [EW-1:0]          j;
  logic [EW:0]            px;
  logic [PW-1:0]          pj;
  logic [EW:0]            pop;
  logic [EW:0]            lim_eff;
  logic [EW-1:0]          slot;
  logic [TIME_BITS:0]     exp_sum;
  logic [TIME_BITS-1:0]   exp_new;
  logic [KEY_BITS-1:0]    ekey;
  logic [VALUE_BITS-1:0]  eval;
  logic [TIME_BITS-1:0]   eexp;

  lttc_ram #(.W(EDW), .D(ENTRIES)) u_entry_ram (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  lttc_ram #(.W(EW), .D(ENTRIES)) u_rank_ram (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(r_raddr), .rdata(r_rdata)
  );

  lttc_ram #(.W(KEY_BITS), .D(PENDING_SLOTS)) u_pend_ram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(item_r.key),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  lttc_stats u_stats (.clk(clk), .rst_n(rst_n), .bump(bump), .stats(stats));

  assign jx  = cnt_r - 1'b1;
  assign j   = jx[EW-1:0];
  assign px  = cnt_r - 1'b1;
  assign pj  = px[PW-1:0];
  assign pop = (EW+1)'($countones(valid_r));
  assign {ekey, eval, eexp} = e_rdata;
  assign exp_sum = {1'b0, item_r.now_ms} + {{(TIME_BITS+1-TTL_BITS){1'b0}}, item_r.ttl_ms};
  assign exp_new = exp_sum[TIME_BITS] ? '1 : exp_sum[TIME_BITS-1:0];

  always_comb begin
    if (lim_r == '0) begin
      lim_eff = (EW+1)'(1);
    end else if ({{(EW+1){1'b0}}, lim_r} > (EW+1+LIMIT_BITS)'(ENTRIES)) begin
      lim_eff = (EW+1)'(ENTRIES);
    end else begin
      lim_eff = (EW+1)'(lim_r);
    end
  end

  always_comb begin
    slot = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) slot = EW'(i);
    end
  end

  assign e_raddr = cnt_r[EW-1:0];
  assign r_raddr = cnt_r[EW-1:0];
  assign p_raddr = cnt_r[PW-1:0];
  assign e_waddr = slot;
  assign e_wdata = {item_r.key, item_r.fill_value, exp_new};
  assign e_we    = (state_r == S_WRITE);
  assign p_waddr = pfree_r;

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    cnt_nxt       = cnt_r;
    item_nxt      = item_r;
    valid_nxt     = valid_r;
    pvalid_nxt    = pvalid_r;
    lim_nxt       = lim_r;
    found_nxt     = found_r;
    s_nxt         = s_r;
    rank_nxt      = rank_r;
    val_nxt       = val_r;
    exp_nxt       = exp_r;
    pm_nxt        = pm_r;
    pf_nxt        = pf_r;
    pfree_nxt     = pfree_r;
    evf_nxt       = evf_r;
    tgt_nxt       = tgt_r;
    status_nxt    = status_r;
    rval_nxt      = rval_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    bump          = '0;
    r_we          = 1'b0;
    r_waddr       = j;
    r_wdata       = r_rdata;
    p_we          = 1'b0;

    if (cfg_valid) lim_nxt = cfg_data;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          cnt_nxt   = '0;
          found_nxt = 1'b0;
          pm_nxt    = 1'b0;
          pf_nxt    = 1'b0;
          rval_nxt  = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt_r != '0) begin
          if (valid_r[j] && ekey == item_r.key && !found_r) begin
            found_nxt = 1'b1;
            s_nxt     = j;
            rank_nxt  = r_rdata;
            val_nxt   = eval;
            exp_nxt   = eexp;
          end
          if (cnt_r <= (EW+1)'(PENDING_SLOTS)) begin
            if (item_r.action == ACT_FILL) begin
              if (pvalid_r[pj] && p_rdata == item_r.key) pvalid_nxt[pj] = 1'b0;
            end else if (pvalid_r[pj]) begin
              if (p_rdata == item_r.key) pm_nxt = 1'b1;
            end else if (!pf_r) begin
              pf_nxt    = 1'b1;
              pfree_nxt = pj;
            end
          end
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (EW+1)'(ENTRIES)) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cnt_nxt   = '0;
        state_nxt = S_FINISH;
        case (item_r.action)
          ACT_LOOKUP: begin
            if (found_r && exp_r > item_r.now_ms) begin
              bump.hit   = 1'b1;
              status_nxt = ST_HIT;
              rval_nxt   = val_r;
              mode_nxt   = M_HIT;
              state_nxt  = S_PASS;
            end else begin
              if (pm_r) begin
                bump.merged = 1'b1;
                status_nxt  = ST_MERGED;
              end else if (pf_r) begin
                p_we               = 1'b1;
                pvalid_nxt[pfree_r] = 1'b1;
                bump.miss          = 1'b1;
                status_nxt         = ST_MISS;
              end else begin
                status_nxt = ST_FULL;
              end
              if (found_r) begin
                mode_nxt  = M_REMOVE;
                state_nxt = S_PASS;
              end
            end
          end
          ACT_FILL: begin
            if (item_r.fill_ok) begin
              status_nxt = ST_STORED;
              rval_nxt   = item_r.fill_value;
              mode_nxt   = M_FILL;
              evf_nxt    = !found_r && pop == (EW+1)'(ENTRIES);
              state_nxt  = S_PASS;
            end else begin
              status_nxt = ST_FAILED;
            end
          end
          ACT_INVAL: begin
            if (found_r) begin
              status_nxt = ST_INVAL;
              mode_nxt   = M_REMOVE;
              state_nxt  = S_PASS;
            end else begin
              status_nxt = ST_ABSENT;
            end
          end
          default: begin
            valid_nxt  = '0;
            status_nxt = ST_CLEARED;
          end
        endcase
      end
      S_PASS: begin
        if (cnt_r != '0) begin
          unique case (mode_r)
            M_HIT: begin
              if (j == s_r) begin
                r_we    = 1'b1;
                r_wdata = '0;
              end else if (valid_r[j] && r_rdata < rank_r) begin
                r_we    = 1'b1;
                r_wdata = r_rdata + 1'b1;
              end
            end
            M_REMOVE: begin
              if (j == s_r) begin
                valid_nxt[j] = 1'b0;
              end else if (valid_r[j] && r_rdata > rank_r) begin
                r_we    = 1'b1;
                r_wdata = r_rdata - 1'b1;
              end
            end
            M_FILL: begin
              if (found_r && j == s_r) begin
                valid_nxt[j] = 1'b0;
              end else if (valid_r[j] && evf_r && r_rdata == EW'(ENTRIES - 1)) begin
                valid_nxt[j] = 1'b0;
                bump.evict   = 1'b1;
              end else if (valid_r[j]) begin
                r_we = 1'b1;
                if (found_r && r_rdata > rank_r) begin
                  r_wdata = r_rdata;
                end else begin
                  r_wdata = r_rdata + 1'b1;
                end
              end
            end
            default: begin
              if (valid_r[j] && {1'b0, r_rdata} == tgt_r) begin
                valid_nxt[j] = 1'b0;
                bump.evict   = 1'b1;
              end
            end
          endcase
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (EW+1)'(ENTRIES)) begin
          if (mode_r == M_FILL) begin
            state_nxt = S_WRITE;
          end else if (mode_r == M_EVICT) begin
            state_nxt = S_LIMIT;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_WRITE: begin
        r_we            = 1'b1;
        r_waddr         = slot;
        r_wdata         = '0;
        valid_nxt[slot] = 1'b1;
        state_nxt       = S_LIMIT;
      end
      S_LIMIT: begin
        if (pop > lim_eff) begin
          tgt_nxt   = pop - 1'b1;
          mode_nxt  = M_EVICT;
          cnt_nxt   = '0;
          state_nxt = S_PASS;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.status         = status_r;
          out_nxt.key_echo       = item_r.key;
          out_nxt.read_value     = rval_r;
          out_nxt.entry_count    = pop;
          out_nxt.hit_count      = stats.hit;
          out_nxt.miss_count     = stats.miss;
          out_nxt.eviction_count = stats.evict;
          out_nxt.merged_count   = stats.merged;
          out_valid_nxt          = 1'b1;
          state_nxt              = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= M_HIT;
      cnt_r       <= '0;
      valid_r     <= '0;
      pvalid_r    <= '0;
      lim_r       <= LIMIT_BITS'(ENTRIES);
      found_r     <= 1'b0;
      pm_r        <= 1'b0;
      pf_r        <= 1'b0;
      evf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      cnt_r       <= cnt_nxt;
      valid_r     <= valid_nxt;
      pvalid_r    <= pvalid_nxt;
      lim_r       <= lim_nxt;
      found_r     <= found_nxt;
      pm_r        <= pm_nxt;
      pf_r        <= pf_nxt;
      evf_r       <= evf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    s_r      <= s_nxt;
    rank_r   <= rank_nxt;
    val_r    <= val_nxt;
    exp_r    <= exp_nxt;
    pfree_r  <= pfree_nxt;
    tgt_r    <= tgt_nxt;
    status_r <= status_nxt;
    rval_r   <= rval_nxt;
    out_r    <= out_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_SCAN))
    else $error("accepted transaction did not start the entry scan");

  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |-> !valid_r[slot])
    else $error("fill writes over a valid entry");

  a_hit_keeps_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PASS && mode_r == M_HIT) |=> (valid_r == $past(valid_r)))
    else $error("recency update changed entry valid bits");
endmodule
